// File: sv/dcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants of the double click classifier.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int unsigned WINDOW_W     = 16;
    localparam int unsigned ELAPSED_W    = 16;
    localparam int unsigned TIME_W       = 17;
    localparam int unsigned PRESS_W      = 2;
    localparam int unsigned S_TDATA_W    = 24;
    localparam int unsigned M_TDATA_W    = 8;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd500;
    localparam logic [TIME_W-1:0]   TIME_MAX     = {TIME_W{1'b1}};
    localparam logic [PRESS_W-1:0]  PRESS_MAX    = {PRESS_W{1'b1}};

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic                 pointer_over;
        logic                 right_down;
        logic                 left_down;
        logic                 enabled;
    } t_tick;

    typedef struct packed {
        logic double_click;
        logic right_click;
        logic left_click;
    } t_click;

    typedef struct packed {
        logic               left_held;
        logic               right_held;
        logic               left_deferred;
        logic               right_deferred;
        logic [PRESS_W-1:0] left_presses;
        logic [PRESS_W-1:0] right_presses;
        logic [TIME_W-1:0]  window_time;
    } t_state;

    function automatic logic [PRESS_W-1:0] bump_count(input logic [PRESS_W-1:0] c);
        return (c == PRESS_MAX) ? PRESS_MAX : c + PRESS_W'(1);
    endfunction

endpackage

// File: sv/dcc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_in_stage
// Input register for one tick; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module dcc_in_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dcc_pkg::S_TDATA_W-1:0] i_data,
    input  logic                         i_take,
    output logic                         o_valid,
    output dcc_pkg::t_tick               o_tick
);
    import dcc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_tick r_tick;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tick <= t_tick'(i_data[$bits(t_tick)-1:0]);
        end
    end

    assign o_valid = r_valid;
    assign o_tick  = r_tick;

endmodule

// File: sv/dcc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_core
// Press, window and deferred-click state with the single-pass tick update.
// ----------------------------------------------------------------------------
module dcc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  dcc_pkg::t_tick                 i_tick,
    input  logic [dcc_pkg::WINDOW_W-1:0]   i_window,
    output dcc_pkg::t_click                o_click,
    output dcc_pkg::t_state                o_state
);
    import dcc_pkg::*;

    t_state r_st;
    t_state n_st;
    t_click n_click;

    logic                 lh1, rh1, ldef1, rdef1;
    logic [PRESS_W-1:0]   lp1, rp1;
    logic [TIME_W:0]      sum;
    logic [TIME_W-1:0]    t1;
    logic                 any_press, over_win, decide;

    always_comb begin
        n_st    = r_st;
        n_click = '0;
        lh1       = r_st.left_held  || i_tick.left_down;
        rh1       = r_st.right_held || i_tick.right_down;
        lp1       = (i_tick.left_down && !r_st.left_held) ?
                    bump_count(r_st.left_presses) : r_st.left_presses;
        rp1       = (i_tick.right_down && !r_st.right_held) ?
                    bump_count(r_st.right_presses) : r_st.right_presses;
        any_press = (lp1 != '0) || (rp1 != '0);
        sum       = {1'b0, r_st.window_time} + (TIME_W+1)'(i_tick.elapsed);
        if (!any_press) begin
            t1 = '0;
        end else if (sum[TIME_W]) begin
            t1 = TIME_MAX;
        end else begin
            t1 = sum[TIME_W-1:0];
        end
        over_win = t1 > TIME_W'(i_window);
        decide   = (lp1 > PRESS_W'(1)) || (rp1 > PRESS_W'(1)) || over_win;
        ldef1    = r_st.left_deferred  || (over_win && (lp1 != '0) && lh1);
        rdef1    = r_st.right_deferred || (over_win && (rp1 != '0) && rh1);

        if (i_tick.enabled) begin
            n_click.double_click = decide && !over_win;
            n_click.left_click   = (over_win && (lp1 != '0) && !lh1) ||
                                   (lh1 && !i_tick.left_down && ldef1 &&
                                    i_tick.pointer_over);
            n_click.right_click  = (over_win && (rp1 != '0) && !rh1) ||
                                   (rh1 && !i_tick.right_down && rdef1 &&
                                    i_tick.pointer_over);
            n_st.left_held       = i_tick.left_down;
            n_st.right_held      = i_tick.right_down;
            n_st.left_deferred   = ldef1 && i_tick.left_down;
            n_st.right_deferred  = rdef1 && i_tick.right_down;
            n_st.left_presses    = decide ? '0 : lp1;
            n_st.right_presses   = decide ? '0 : rp1;
            n_st.window_time     = decide ? '0 : t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_adv) begin
            r_st <= n_st;
        end
    end

    assign o_click = n_click;
    assign o_state = r_st;

endmodule

// File: sv/double_click_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_click_classifier_top
// Click and double-click classifier for one control, one tick per transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one update tick and yields exactly one result
// transfer carrying the left, right and double click flags. A tick passes an
// input register, one short combinational update of the press counters,
// window timer and deferred-click flags, and an output register. A new tick
// is taken every cycle while the result side keeps up. The window register is
// written through the cfg channel (reset 500 ms) and is to be changed only
// while no tick is in flight.
// ----------------------------------------------------------------------------
module double_click_classifier_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // enabled, left_down, right_down, pointer_over, elapsed[15:0], zero pad
    input  logic [dcc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // left_click, right_click, double_click, zero pad
    output logic [dcc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dcc_pkg::WINDOW_W-1:0]  i_cfg_data
);
    import dcc_pkg::*;

    logic                r_out_valid;
    t_click              r_out;
    logic [WINDOW_W-1:0] r_window;
    logic                in_valid;
    t_tick               in_tick;
    logic                adv;
    t_click              click;
    t_state              st;

    assign adv = in_valid && (!r_out_valid || m_axis_tready);

    dcc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_take  (adv),
        .o_valid (in_valid),
        .o_tick  (in_tick)
    );

    dcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_tick   (in_tick),
        .i_window (r_window),
        .o_click  (click),
        .o_state  (st)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= click;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-$bits(t_click)){1'b0}},
                            r_out.double_click, r_out.right_click, r_out.left_click};

    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st.left_presses == '0 && st.right_presses == '0) |-> st.window_time == '0)
        else $error("window timer running with no press counted");

    a_left_defer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.left_deferred |-> st.left_held)
        else $error("left click deferred without the button held");

    a_right_defer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.right_deferred |-> st.right_held)
        else $error("right click deferred without the button held");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> m_axis_tvalid)
        else $error("result not presented after a tick was taken");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double click classifier.
// ----------------------------------------------------------------------------
// Ticks go in on the input stream. A predictor in the bench tracks the press
// counts, the window timer and the deferred clicks, and queues the expected
// click flags for each accepted tick. A monitor compares every result
// transfer with the oldest queued entry. Directed tests cover single, double
// and deferred clicks, disabled ticks and the window limits. Random streams of
// button activity follow under several window settings, with random gaps on
// both sides and a final stretch without gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import dcc_pkg::*;

    localparam int unsigned IDLE_LIMIT = 5000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // enabled, left_down, right_down, pointer_over, elapsed[15:0], zero pad
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // left_click, right_click, double_click, zero pad
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [WINDOW_W-1:0]    i_cfg_data;

    t_state                 ctl_state;
    logic [WINDOW_W-1:0]    window_ms;
    t_click                 pending_clicks[$];
    t_click                 mon_got;
    t_click                 mon_want;
    int unsigned            fail_count;
    int unsigned            idle_cycles;
    int unsigned            stall_left;
    bit                     idle_on;
    logic                   lvl_left;
    logic                   lvl_right;

    double_click_classifier_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_click classify_tick(input t_tick tk);
        t_click          c;
        logic [TIME_W:0] sum;
        c = '0;
        if (tk.enabled) begin
            if (tk.left_down && !ctl_state.left_held) begin
                ctl_state.left_held = 1'b1;
                if (ctl_state.left_presses != PRESS_MAX)
                    ctl_state.left_presses = ctl_state.left_presses + 1'b1;
            end
            if (tk.right_down && !ctl_state.right_held) begin
                ctl_state.right_held = 1'b1;
                if (ctl_state.right_presses != PRESS_MAX)
                    ctl_state.right_presses = ctl_state.right_presses + 1'b1;
            end
            if (ctl_state.left_presses != 0 || ctl_state.right_presses != 0) begin
                sum = {1'b0, ctl_state.window_time} + tk.elapsed;
                ctl_state.window_time = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
            end else begin
                ctl_state.window_time = '0;
            end
            if (ctl_state.left_presses > 1 || ctl_state.right_presses > 1 ||
                ctl_state.window_time > window_ms) begin
                if (ctl_state.window_time <= window_ms) begin
                    c.double_click = 1'b1;
                end else begin
                    if (ctl_state.left_presses != 0) begin
                        if (ctl_state.left_held) ctl_state.left_deferred = 1'b1;
                        else c.left_click = 1'b1;
                    end
                    if (ctl_state.right_presses != 0) begin
                        if (ctl_state.right_held) ctl_state.right_deferred = 1'b1;
                        else c.right_click = 1'b1;
                    end
                end
                ctl_state.left_presses  = '0;
                ctl_state.right_presses = '0;
                ctl_state.window_time   = '0;
            end
            if (ctl_state.left_held && !tk.left_down) begin
                ctl_state.left_held = 1'b0;
                if (ctl_state.left_deferred && tk.pointer_over) c.left_click = 1'b1;
                ctl_state.left_deferred = 1'b0;
            end
            if (ctl_state.right_held && !tk.right_down) begin
                ctl_state.right_held = 1'b0;
                if (ctl_state.right_deferred && tk.pointer_over) c.right_click = 1'b1;
                ctl_state.right_deferred = 1'b0;
            end
        end
        return c;
    endfunction

    task automatic send_tick(input logic en, input logic ld, input logic rd,
                             input logic over, input logic [ELAPSED_W-1:0] ms);
        t_tick                tk;
        logic [S_TDATA_W-1:0] word;
        int unsigned          gap;
        tk.enabled      = en;
        tk.left_down    = ld;
        tk.right_down   = rd;
        tk.pointer_over = over;
        tk.elapsed      = ms;
        word = '0;
        word[$bits(t_tick)-1:0] = tk;
        gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_clicks.push_back(classify_tick(tk));
        @(negedge i_clk);
    endtask

    task automatic drain_clicks();
        s_axis_tvalid <= 1'b0;
        while (pending_clicks.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_window(input logic [WINDOW_W-1:0] value);
        drain_clicks();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        window_ms = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Default window of 500 ms, straight out of reset
    task automatic test_basic_clicks();
        send_tick(1, 1, 0, 1, 16'd0);
        send_tick(1, 0, 0, 1, 16'd100);
        send_tick(1, 0, 0, 1, 16'd401);
        send_tick(1, 1, 0, 1, 16'd0);
        send_tick(1, 0, 0, 1, 16'd200);
        send_tick(1, 1, 0, 1, 16'd300);
        send_tick(1, 0, 0, 1, 16'd0);
        send_tick(1, 0, 1, 1, 16'd0);
        send_tick(1, 0, 1, 1, 16'd501);
        send_tick(1, 0, 0, 1, 16'd10);
        send_tick(1, 1, 0, 0, 16'd0);
        send_tick(1, 1, 0, 0, 16'hFFFF);
        send_tick(1, 0, 0, 0, 16'd0);
        send_tick(1, 0, 1, 1, 16'd0);
        send_tick(0, 1, 0, 1, 16'hFFFF);
        send_tick(0, 0, 0, 0, 16'd0);
        send_tick(1, 0, 0, 1, 16'd600);
        send_tick(1, 1, 1, 1, 16'd0);
        send_tick(1, 0, 0, 1, 16'd0);
        send_tick(1, 0, 0, 1, 16'hFFFF);
        send_tick(1, 0, 1, 0, 16'd0);
        send_tick(1, 0, 0, 0, 16'd20);
        send_tick(1, 0, 1, 0, 16'd30);
        send_tick(1, 0, 0, 0, 16'd0);
    endtask

    task automatic test_window_limits();
        set_window(16'd0);
        send_tick(1, 1, 0, 1, 16'd0);
        send_tick(1, 0, 0, 1, 16'd1);
        set_window(16'hFFFF);
        send_tick(1, 1, 0, 1, 16'hFFFF);
        send_tick(1, 1, 0, 1, 16'hFFFF);
        send_tick(1, 0, 0, 1, 16'd0);
        set_window(16'd1);
        send_tick(1, 0, 1, 1, 16'd1);
        send_tick(1, 0, 0, 1, 16'd1);
    endtask

    task automatic test_random_stream(input int unsigned count);
        logic [ELAPSED_W-1:0] ms;
        logic [ELAPSED_W:0]   span;
        int unsigned          pick;
        span = (ELAPSED_W+1)'({1'b0, window_ms} / 2 + 1);
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(0, 2) == 0) lvl_left  = ~lvl_left;
            if ($urandom_range(0, 3) == 0) lvl_right = ~lvl_right;
            pick = $urandom_range(0, 7);
            if (pick == 0)      ms = ELAPSED_W'($urandom);
            else if (pick == 1) ms = '0;
            else                ms = ELAPSED_W'($urandom_range(0, span));
            send_tick($urandom_range(0, 15) != 0, lvl_left, lvl_right,
                      $urandom_range(0, 3) != 0, ms);
        end
    endtask

    // Hold the sender until every expected result is back, then resume
    task automatic test_drain_pause();
        test_random_stream(100);
        drain_clicks();
        test_random_stream(100);
    endtask

    always @(negedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got = m_axis_tdata[$bits(t_click)-1:0];
            if (pending_clicks.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected click transfer: L%0b R%0b D%0b",
                             mon_got.left_click, mon_got.right_click,
                             mon_got.double_click);
            end else begin
                mon_want = pending_clicks.pop_front();
                if (mon_got !== mon_want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("click mismatch: expected L%0b R%0b D%0b, got L%0b R%0b D%0b",
                                 mon_want.left_click, mon_want.right_click,
                                 mon_want.double_click, mon_got.left_click,
                                 mon_got.right_click, mon_got.double_click);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        ctl_state     = '0;
        window_ms     = WINDOW_RESET;
        fail_count    = 0;
        idle_cycles   = 0;
        stall_left    = 0;
        idle_on       = 1'b1;
        lvl_left      = 1'b0;
        lvl_right     = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_clicks();
        test_window_limits();
        set_window(16'd500);
        test_random_stream(250);
        set_window(16'd1);
        test_random_stream(250);
        set_window(16'hFFFF);
        test_random_stream(250);
        set_window(WINDOW_W'($urandom_range(2, 65534)));
        test_random_stream(250);
        set_window(16'd40);
        test_drain_pause();
        set_window(16'd0);
        test_random_stream(150);
        set_window(WINDOW_W'($urandom_range(100, 2000)));
        test_random_stream(250);
        idle_on = 1'b0;
        set_window(16'd250);
        test_random_stream(150);

        drain_clicks();
        repeat (6) @(negedge i_clk);
        if (pending_clicks.size() != 0) begin
            fail_count += pending_clicks.size();
            $display("%0d click results never arrived", pending_clicks.size());
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
